@@ hw/rtl/lns_pkg.sv @@
// ----------------------------------------------------------------------------
// lns_pkg
// Types and constants shared by the Lambertian shading pipeline.
// ----------------------------------------------------------------------------
package lns_pkg;

	localparam int CoordW = 24;
	localparam int NormW  = 16;
	localparam int ShadeW = 8;
	localparam int IdxW   = 2;

	localparam logic [IdxW-1:0] REG_LIGHT_X = 2'd0;
	localparam logic [IdxW-1:0] REG_LIGHT_Y = 2'd1;
	localparam logic [IdxW-1:0] REG_LIGHT_Z = 2'd2;

	localparam logic [ShadeW-1:0] SHADE_ZERO_LEN = 8'd127;

	typedef struct packed {
		logic [49:0]        q;
		logic signed [42:0] s;
	} front_t;

	typedef struct packed {
		logic [49:0]       q;
		logic [99:0]       b;
		logic              s_neg;
		logic              q_zero;
		logic [ShadeW-1:0] k;
	} srch_t;

	typedef logic [15:0] a2_tab_t [256];

	function automatic a2_tab_t build_a2_tab();
		a2_tab_t t;
		int      a;
		for (int i = 0; i < 256; i++) begin
			a    = 2 * i - 255;
			t[i] = 16'(a * a);
		end
		return t;
	endfunction

	// Square of (2k - 255) for every candidate level k.
	localparam a2_tab_t A2_TAB = build_a2_tab();

endpackage

@@ hw/rtl/lns_front.sv @@
// ----------------------------------------------------------------------------
// lns_front
// Light vector, squared length and dot product with the normal (three stages).
// ----------------------------------------------------------------------------
module lns_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                in_valid,
	input  logic signed [lns_pkg::CoordW-1:0]   light_x,
	input  logic signed [lns_pkg::CoordW-1:0]   light_y,
	input  logic signed [lns_pkg::CoordW-1:0]   light_z,
	input  logic signed [lns_pkg::CoordW-1:0]   vertex_x,
	input  logic signed [lns_pkg::CoordW-1:0]   vertex_y,
	input  logic signed [lns_pkg::CoordW-1:0]   vertex_z,
	input  logic signed [lns_pkg::NormW-1:0]    normal_x,
	input  logic signed [lns_pkg::NormW-1:0]    normal_y,
	input  logic signed [lns_pkg::NormW-1:0]    normal_z,
	output logic                                out_valid,
	output lns_pkg::front_t                     out_data
);
	import lns_pkg::*;

	logic               v_s1, v_s2;
	logic signed [24:0] dx_s1, dy_s1, dz_s1;
	logic signed [15:0] nx_s1, ny_s1, nz_s1;
	logic [48:0]        sqx_s2, sqy_s2, sqz_s2;
	logic signed [40:0] pnx_s2, pny_s2, pnz_s2;
	logic signed [49:0] sqx, sqy, sqz;
	logic signed [40:0] pnx, pny, pnz;

	always_comb begin
		sqx = dx_s1 * dx_s1;
		sqy = dy_s1 * dy_s1;
		sqz = dz_s1 * dz_s1;
		pnx = nx_s1 * dx_s1;
		pny = ny_s1 * dy_s1;
		pnz = nz_s1 * dz_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			out_valid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1    <= 25'(light_x) - 25'(vertex_x);
			dy_s1    <= 25'(light_y) - 25'(vertex_y);
			dz_s1    <= 25'(light_z) - 25'(vertex_z);
			nx_s1    <= normal_x;
			ny_s1    <= normal_y;
			nz_s1    <= normal_z;
			sqx_s2   <= sqx[48:0];
			sqy_s2   <= sqy[48:0];
			sqz_s2   <= sqz[48:0];
			pnx_s2   <= pnx;
			pny_s2   <= pny;
			pnz_s2   <= pnz;
			out_data.q <= 50'(sqx_s2) + 50'(sqy_s2) + 50'(sqz_s2);
			out_data.s <= 43'(pnx_s2) + 43'(pny_s2) + 43'(pnz_s2);
		end
	end

endmodule

@@ hw/rtl/lns_square.sv @@
// ----------------------------------------------------------------------------
// lns_square
// Squares 255 times the magnitude of the dot product (three stages).
// ----------------------------------------------------------------------------
module lns_square (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  lns_pkg::front_t  in_data,
	output logic             out_valid,
	output lns_pkg::srch_t   out_data
);
	import lns_pkg::*;

	logic        v_s1, v_s2;
	logic [42:0] mag;
	logic [49:0] ub_s1;
	logic [49:0] hh_s2, hl_s2, ll_s2;
	logic [49:0] q_s1, q_s2;
	logic        neg_s1, neg_s2, zero_s1, zero_s2;

	assign mag = in_data.s[42] ? 43'(-in_data.s) : 43'(in_data.s);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			out_valid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ub_s1   <= {mag[41:0], 8'b0} - 50'(mag[41:0]);
			q_s1    <= in_data.q;
			neg_s1  <= in_data.s[42];
			zero_s1 <= (in_data.q == '0);
			hh_s2   <= 50'(ub_s1[49:25]) * 50'(ub_s1[49:25]);
			hl_s2   <= 50'(ub_s1[49:25]) * 50'(ub_s1[24:0]);
			ll_s2   <= 50'(ub_s1[24:0]) * 50'(ub_s1[24:0]);
			q_s2    <= q_s1;
			neg_s2  <= neg_s1;
			zero_s2 <= zero_s1;
			out_data.b      <= {hh_s2, 50'b0} + 100'({hl_s2, 26'b0}) + 100'(ll_s2);
			out_data.q      <= q_s2;
			out_data.s_neg  <= neg_s2;
			out_data.q_zero <= zero_s2;
			out_data.k      <= '0;
		end
	end

endmodule

@@ hw/rtl/lns_step.sv @@
// ----------------------------------------------------------------------------
// lns_step
// One bit of the shade level search: multiply stage, then compare stage.
// ----------------------------------------------------------------------------
module lns_step (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  lns_pkg::srch_t              in_data,
	input  logic [lns_pkg::ShadeW-1:0]  step_bit,
	output logic                        out_valid,
	output lns_pkg::srch_t              out_data
);
	import lns_pkg::*;

	logic              v_s1;
	srch_t             d_s1;
	srch_t             nxt;
	logic [65:0]       prod_s1;
	logic [ShadeW-1:0] cand, cand_s1;
	logic [99:0]       lhs;
	logic              ok;

	assign cand    = in_data.k | step_bit;
	assign cand_s1 = d_s1.k | step_bit;
	assign lhs     = {6'b0, prod_s1, 28'b0};

	// Levels up to 127 have a negative threshold, the rest a positive one.
	always_comb begin
		if (!cand_s1[ShadeW-1]) begin
			ok = !d_s1.s_neg || (d_s1.b <= lhs);
		end else begin
			ok = !d_s1.s_neg && (lhs <= d_s1.b);
		end
	end

	always_comb begin
		nxt   = d_s1;
		nxt.k = ok ? cand_s1 : d_s1.k;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1      <= in_valid;
			out_valid <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1     <= in_data;
			prod_s1  <= 66'(A2_TAB[cand]) * 66'(in_data.q);
			out_data <= nxt;
		end
	end

	a_high_bits_kept: assert property (@(posedge clk) disable iff (!arst_n)
		en && v_s1 |=> (out_data.k & ~step_bit) == $past(d_s1.k & ~step_bit))
		else $error("search step altered a decided level bit");

	a_low_bits_clear: assert property (@(posedge clk) disable iff (!arst_n)
		en && v_s1 |=> (out_data.k & (step_bit - 8'd1)) == '0)
		else $error("search step set an undecided level bit");

endmodule

@@ hw/rtl/lambert_normal_shading.sv @@
// ----------------------------------------------------------------------------
// lambert_normal_shading
// Lambertian diffuse shade byte from a vertex, a unit normal and a light.
//
//   channel   signals                                  direction
//   input     in_valid, in_stall, vertex_*, normal_*   into the block, but for in_stall
//   output    out_valid, out_stall, shade              out of the block, but for out_stall
//   config    wr_en, wr_index, wr_data                 into the block
//
// One pixel is taken per cycle while not held by out_stall; each goes through
// 23 register stages: three front stages, three squaring stages and two stages
// for each of the eight bits of the level search, plus the output register.
// Reset clears the light position and all valid bits.
// The whole pipeline holds while a result waits under out_stall; no transfer
// is lost or repeated.
// ----------------------------------------------------------------------------
module lambert_normal_shading (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [lns_pkg::CoordW-1:0]  vertex_x,
	input  logic signed [lns_pkg::CoordW-1:0]  vertex_y,
	input  logic signed [lns_pkg::CoordW-1:0]  vertex_z,
	input  logic signed [lns_pkg::NormW-1:0]   normal_x,
	input  logic signed [lns_pkg::NormW-1:0]   normal_y,
	input  logic signed [lns_pkg::NormW-1:0]   normal_z,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [lns_pkg::ShadeW-1:0]         shade,
	input  logic                               wr_en,
	input  logic [lns_pkg::IdxW-1:0]           wr_index,
	input  logic [lns_pkg::CoordW-1:0]         wr_data
);
	import lns_pkg::*;

	logic signed [CoordW-1:0] light_x_q, light_y_q, light_z_q;
	logic                     en;
	logic                     front_valid, sq_valid;
	front_t                   front_data;
	logic                     chain_valid [9];
	srch_t                    chain_data  [9];

	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_x_q <= '0;
			light_y_q <= '0;
			light_z_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_LIGHT_X: light_x_q <= wr_data;
				REG_LIGHT_Y: light_y_q <= wr_data;
				REG_LIGHT_Z: light_z_q <= wr_data;
				default: ;
			endcase
		end
	end

	lns_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid),
		.light_x   (light_x_q),
		.light_y   (light_y_q),
		.light_z   (light_z_q),
		.vertex_x  (vertex_x),
		.vertex_y  (vertex_y),
		.vertex_z  (vertex_z),
		.normal_x  (normal_x),
		.normal_y  (normal_y),
		.normal_z  (normal_z),
		.out_valid (front_valid),
		.out_data  (front_data)
	);

	lns_square u_square (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (front_valid),
		.in_data   (front_data),
		.out_valid (sq_valid),
		.out_data  (chain_data[0])
	);

	assign chain_valid[0] = sq_valid;

	for (genvar i = 0; i < ShadeW; i++) begin : g_step
		lns_step u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (chain_valid[i]),
			.in_data   (chain_data[i]),
			.step_bit  (8'(8'h80 >> i)),
			.out_valid (chain_valid[i+1]),
			.out_data  (chain_data[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= chain_valid[ShadeW];
		end
	end

	// A zero-length light vector gives the mid level.
	always_ff @(posedge clk) begin
		if (en) begin
			shade <= chain_data[ShadeW].q_zero ? SHADE_ZERO_LEN : chain_data[ShadeW].k;
		end
	end

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input held off without a waiting result");

endmodule
